@@ design/srec_pkg.sv @@
// shared types, codes and lookup functions for the s-record line checker
package srec_pkg;

    localparam int POS_W = 7;

    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
    localparam logic [7:0] SUM_GOOD  = 8'hFF;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BAD_CHAR    = 4'd1,
        ST_NO_S        = 4'd2,
        ST_BAD_TYPE    = 4'd3,
        ST_BAD_LENGTH  = 4'd4,
        ST_COUNT       = 4'd5,
        ST_CHECKSUM    = 4'd6,
        ST_S0_ADDR     = 4'd7,
        ST_S5_MISMATCH = 4'd8
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       byte_sum;
        logic [3:0]       high_nibble;
        logic [7:0]       count_byte;
        logic [3:0]       record_type;
        logic             no_s;
        logic             bad_char;
        logic             type_hex;
        logic             addr_zero;
        logic [15:0]      s5_value;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        pos: '0, byte_sum: '0, high_nibble: '0, count_byte: '0,
        record_type: '0, no_s: 1'b0, bad_char: 1'b0, type_hex: 1'b0,
        addr_zero: 1'b1, s5_value: '0
    };

    // {valid, nibble}; only 0-9 and upper-case A-F count as hex
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                v = c - CHAR_ZERO;
                hex_decode = {1'b1, v[3:0]};
            end
            else if (c >= CHAR_A && c <= CHAR_F)
            begin
                v = c - HEX_ALPHA_OFS;
                hex_decode = {1'b1, v[3:0]};
            end
            else
            begin
                hex_decode = 5'd0;
            end
        end
    endfunction

    function automatic logic type_ok(input logic [3:0] t);
        type_ok = (t <= 4'd9) && (t != 4'd4) && (t != 4'd6);
    endfunction

    function automatic logic [7:0] len_min(input logic [3:0] t);
        case (t)
            4'd0:    len_min = 8'd10;
            4'd1:    len_min = 8'd12;
            4'd2:    len_min = 8'd14;
            4'd3:    len_min = 8'd16;
            4'd5:    len_min = 8'd10;
            4'd7:    len_min = 8'd14;
            4'd8:    len_min = 8'd12;
            4'd9:    len_min = 8'd10;
            default: len_min = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] len_max(input logic [3:0] t);
        case (t)
            4'd0:    len_max = 8'd74;
            4'd1:    len_max = 8'd74;
            4'd2:    len_max = 8'd76;
            4'd3:    len_max = 8'd78;
            4'd5:    len_max = 8'd10;
            4'd7:    len_max = 8'd14;
            4'd8:    len_max = 8'd12;
            4'd9:    len_max = 8'd10;
            default: len_max = 8'd0;
        endcase
    endfunction

endpackage

@@ design/srec_char_tracker.sv @@
// per-line running state: position, nibble pairing, byte sum and field captures
module srec_char_tracker
    import srec_pkg::*;
#(
    parameter int MAX_RECORD_CHARS = 78
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        eol,
    input  logic [7:0]  char_code,
    output line_state_t line_state
);

    localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_RECORD_CHARS + 1);

    line_state_t st_reg;
    line_state_t st_next;
    logic [4:0]  hex;
    logic        is_hex;
    logic [3:0]  nib;

    assign hex    = hex_decode(char_code);
    assign is_hex = hex[4];
    assign nib    = hex[3:0];

    always_comb
    begin
        st_next = st_reg;
        if (take && eol)
        begin
            st_next = LINE_CLEAR;
        end
        else if (take && st_reg.pos != POS_SAT)
        begin
            st_next.pos = st_reg.pos + POS_W'(1);
            if (st_reg.pos == POS_W'(0))
            begin
                if (char_code != CHAR_S)
                    st_next.no_s = 1'b1;
            end
            else
            begin
                if (!is_hex)
                    st_next.bad_char = 1'b1;
                if (st_reg.pos == POS_W'(1))
                begin
                    if (is_hex)
                    begin
                        st_next.record_type = nib;
                        st_next.type_hex    = 1'b1;
                    end
                end
                else
                begin
                    if (!st_reg.pos[0])
                        st_next.high_nibble = nib;
                    else
                    begin
                        st_next.byte_sum = st_reg.byte_sum + {st_reg.high_nibble, nib};
                        if (st_reg.pos == POS_W'(3))
                            st_next.count_byte = {st_reg.high_nibble, nib};
                    end
                    // address characters
                    if (st_reg.pos >= POS_W'(4) && st_reg.pos <= POS_W'(7))
                    begin
                        if (char_code != CHAR_ZERO)
                            st_next.addr_zero = 1'b0;
                        st_next.s5_value = {st_reg.s5_value[11:0], nib};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= LINE_CLEAR;
        else
            st_reg <= st_next;
    end

    assign line_state = st_reg;

    pos_never_past_sat: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pos <= POS_SAT)
        else $error("character position beyond saturation");

    eol_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        take && eol |=> st_reg.pos == POS_W'(0) && st_reg.addr_zero)
        else $error("line state not cleared at line end");

    sat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pos == POS_SAT && !(take && eol) |=> st_reg.pos == POS_SAT)
        else $error("saturated position moved without line end");

endmodule

@@ design/srec_line_judge.sv @@
// line-end checks in priority order and data-record classification
module srec_line_judge
    import srec_pkg::*;
#(
    parameter int MAX_RECORD_CHARS = 78
)
(
    input  line_state_t line_state,
    input  logic [15:0] data_count,
    output status_t     status,
    output logic        is_data_line
);

    localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_RECORD_CHARS + 1);

    logic [7:0] len;
    logic [8:0] count_chars;
    logic [8:0] payload_chars;

    assign len           = 8'(line_state.pos);
    assign count_chars   = {line_state.count_byte, 1'b0};
    assign payload_chars = 9'(len) - 9'd4;

    assign is_data_line = (line_state.pos >= POS_W'(2)) && !line_state.no_s
                          && line_state.type_hex
                          && (line_state.record_type >= 4'd1)
                          && (line_state.record_type <= 4'd3);

    always_comb
    begin
        if (line_state.pos == POS_SAT)
            status = ST_BAD_LENGTH;
        else if (len == 8'd0 || line_state.no_s)
            status = ST_NO_S;
        else if (line_state.bad_char)
            status = ST_BAD_CHAR;
        else if (len < 8'd2 || !line_state.type_hex || !type_ok(line_state.record_type))
            status = ST_BAD_TYPE;
        else if (len[0] || len < len_min(line_state.record_type)
                 || len > len_max(line_state.record_type))
            status = ST_BAD_LENGTH;
        else if (count_chars != payload_chars)
            status = ST_COUNT;
        else if (line_state.byte_sum != SUM_GOOD)
            status = ST_CHECKSUM;
        else if (line_state.record_type == 4'd0 && !line_state.addr_zero)
            status = ST_S0_ADDR;
        else if (line_state.record_type == 4'd5 && line_state.s5_value != data_count)
            status = ST_S5_MISMATCH;
        else
            status = ST_OK;
    end

endmodule

@@ design/srec_record_checker_core.sv @@
// top level of the s-record line checker: input register, state, result register
//
// usage:
//   s_axis carries one text line, one ascii character per transaction in
//   tdata; a transaction with tlast high is the line feed that closes the
//   line (its tdata is ignored). every closed line yields exactly one
//   m_axis transaction with the status code, the line number since reset
//   and the running count of S1-S3 lines.
// path: a line-end transaction moves from the input register into the result
//   register, which drives m_axis; it waits in the input register while an
//   earlier result is still pending on m_axis.
// throughput: one transaction per cycle on s_axis, save a held line end (see stall);
//   the per-line state is a single register set fed by the input register.
// reset: rst_n low clears the line state, both counters and the valid flags;
//   the next accepted character starts line 1.
// stall: while a result waits on m_axis, characters keep flowing in; only a
//   second line end is held in the input register until the result is taken.
module srec_record_checker_core
    import srec_pkg::*;
#(
    parameter int MAX_RECORD_CHARS = 78
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [3:0] status, [19:4] line_number,
                                        // [35:20] data_record_count, [39:36] zero
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_eol_reg;
    logic        in_advance;
    logic        out_load;
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [15:0] line_cnt_reg;
    logic [15:0] data_cnt_reg;
    logic [15:0] data_cnt_next;

    line_state_t line_state;
    status_t     status;
    logic        is_data_line;

    assign in_advance    = in_valid_reg && (!in_eol_reg || !out_valid_reg || m_axis_tready);
    assign out_load      = in_advance && in_eol_reg;
    assign s_axis_tready = !in_valid_reg || in_advance;
    assign data_cnt_next = data_cnt_reg + {15'd0, is_data_line};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_char_reg  <= '0;
            in_eol_reg   <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            in_char_reg  <= s_axis_tdata;
            in_eol_reg   <= s_axis_tlast;
        end
    end

    srec_char_tracker #(
        .MAX_RECORD_CHARS(MAX_RECORD_CHARS)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (in_advance),
        .eol        (in_eol_reg),
        .char_code  (in_char_reg),
        .line_state (line_state)
    );

    srec_line_judge #(
        .MAX_RECORD_CHARS(MAX_RECORD_CHARS)
    ) u_judge (
        .line_state   (line_state),
        .data_count   (data_cnt_reg),
        .status       (status),
        .is_data_line (is_data_line)
    );

    // counters update only with a result load, so they double as result fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            line_cnt_reg   <= '0;
            data_cnt_reg   <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg  <= 1'b1;
            out_status_reg <= status;
            line_cnt_reg   <= line_cnt_reg + 16'd1;
            data_cnt_reg   <= data_cnt_next;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, data_cnt_reg, line_cnt_reg, out_status_reg};

    load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("result not presented after line end");

    line_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> line_cnt_reg == $past(line_cnt_reg) + 16'd1)
        else $error("line number did not advance by one");

    counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(line_cnt_reg) && $stable(data_cnt_reg))
        else $error("counters changed without a line end");

    no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg || m_axis_tready)
        else $error("pending result overwritten");

endmodule

@@ tb/tb_srec_record_checker_core.sv @@
// self-checking testbench for the s-record line checker core
module tb_srec_record_checker_core;
    import srec_pkg::*;

    localparam int MAX_CHARS = 78;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 100;
    localparam int MIN_RANDOM_LINES = 8;

    // s-record type digits
    localparam logic [3:0] REC_HDR   = 4'd0;
    localparam logic [3:0] REC_D16   = 4'd1;
    localparam logic [3:0] REC_D24   = 4'd2;
    localparam logic [3:0] REC_D32   = 4'd3;
    localparam logic [3:0] REC_BAD4  = 4'd4;
    localparam logic [3:0] REC_CNT16 = 4'd5;
    localparam logic [3:0] REC_BAD6  = 4'd6;
    localparam logic [3:0] REC_END32 = 4'd7;
    localparam logic [3:0] REC_END24 = 4'd8;
    localparam logic [3:0] REC_END16 = 4'd9;
    localparam logic [3:0] REC_BADA  = 4'hA;
    localparam logic [3:0] REC_BADF  = 4'hF;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_X       = 8'h58;
    localparam logic [7:0] CHAR_Q       = 8'h51;

    // allowed character count per type digit, zero for the illegal type digits
    localparam int MIN_CHARS [16] = '{10, 12, 14, 16, 0, 10, 0, 14, 12, 10,
                                      0, 0, 0, 0, 0, 0};
    localparam int MAX_LINE [16]  = '{74, 74, 76, 78, 0, 10, 0, 14, 12, 10,
                                      0, 0, 0, 0, 0, 0};

    typedef enum int {
        MUT_ANY_CHAR,
        MUT_HEX_CHAR,
        MUT_DROP,
        MUT_INSERT,
        MUT_CHECKSUM,
        MUT_TYPE,
        MUT_TRUNCATE,
        MUT_PAD,
        MUT_LOWER
    } corrupt_t;

    typedef struct {
        status_t     status;
        logic [15:0] line_no;
        logic [15:0] data_lines;
    } line_result_t;

    class srec_line_scoreboard;
        logic [6:0]   pos;
        logic [7:0]   sum;
        logic [3:0]   hi_nib;
        logic [7:0]   count_field;
        logic [3:0]   rtype;
        bit           no_s;
        bit           bad_char;
        bit           type_seen;
        bit           addr_zero;
        logic [15:0]  s5_addr;
        logic [15:0]  data_lines;
        logic [15:0]  lines;
        line_result_t line_results_q[$];
        int           errors;

        function new();
            errors = 0;
            data_lines = '0;
            lines = '0;
            clear_line();
        endfunction

        function void clear_line();
            pos = '0;
            sum = '0;
            hi_nib = '0;
            count_field = '0;
            rtype = '0;
            no_s = 0;
            bad_char = 0;
            type_seen = 0;
            addr_zero = 1;
            s5_addr = '0;
        endfunction

        function int pending();
            return line_results_q.size();
        endfunction

        function void take_char(logic [7:0] c);
            int         idx;
            logic [3:0] nib;
            bit         is_hex;
            logic [7:0] b;
            idx = pos;
            if (idx > MAX_CHARS)
                return;
            pos = 7'(idx + 1);
            if (idx == 0)
            begin
                if (c != CHAR_S)
                    no_s = 1;
                return;
            end
            is_hex = 1;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                nib = c[3:0];
            else if (c >= CHAR_A && c <= CHAR_F)
                nib = 4'(c - HEX_ALPHA_OFS);
            else
            begin
                nib = '0;
                is_hex = 0;
            end
            if (!is_hex)
                bad_char = 1;
            if (idx == 1)
            begin
                if (is_hex)
                begin
                    rtype = nib;
                    type_seen = 1;
                end
                return;
            end
            if (idx % 2 == 0)
                hi_nib = nib;
            else
            begin
                b = {hi_nib, nib};
                sum = sum + b;
                if (idx == 3)
                    count_field = b;
            end
            if (idx >= 4 && idx <= 7)
            begin
                if (c != CHAR_ZERO)
                    addr_zero = 0;
                s5_addr = {s5_addr[11:0], nib};
            end
        endfunction

        function status_t line_status();
            int len;
            len = pos;
            if (len > MAX_CHARS)
                return ST_BAD_LENGTH;
            if (len == 0 || no_s)
                return ST_NO_S;
            if (bad_char)
                return ST_BAD_CHAR;
            if (len < 2 || !type_seen || rtype > 9 || rtype == REC_BAD4 || rtype == REC_BAD6)
                return ST_BAD_TYPE;
            if (len % 2 != 0 || len < MIN_CHARS[rtype] || len > MAX_LINE[rtype])
                return ST_BAD_LENGTH;
            if (2 * int'(count_field) != len - 4)
                return ST_COUNT;
            if (sum != SUM_GOOD)
                return ST_CHECKSUM;
            if (rtype == REC_HDR && !addr_zero)
                return ST_S0_ADDR;
            if (rtype == REC_CNT16 && s5_addr != data_lines)
                return ST_S5_MISMATCH;
            return ST_OK;
        endfunction

        function void note_item(logic [7:0] c, logic eol);
            line_result_t r;
            if (!eol)
            begin
                take_char(c);
                return;
            end
            lines = lines + 16'd1;
            // type digit 1-3 counts even if the line fails later checks
            if (pos >= 2 && !no_s && type_seen && rtype >= REC_D16 && rtype <= REC_D32)
                data_lines = data_lines + 16'd1;
            r.status = line_status();
            r.line_no = lines;
            r.data_lines = data_lines;
            line_results_q.push_back(r);
            clear_line();
        endfunction

        function void check_result(logic [39:0] d);
            line_result_t r;
            if (line_results_q.size() == 0)
            begin
                $display("%0t: unexpected line result, actual %h", $time, d);
                errors++;
                return;
            end
            r = line_results_q.pop_front();
            if (d[3:0] != r.status)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d (line %0d)",
                         $time, r.status, d[3:0], r.line_no);
                errors++;
            end
            if (d[19:4] != r.line_no)
            begin
                $display("%0t: line_number mismatch, expected %0d actual %0d",
                         $time, r.line_no, d[19:4]);
                errors++;
            end
            if (d[35:20] != r.data_lines)
            begin
                $display("%0t: data_record_count mismatch, expected %0d actual %0d",
                         $time, r.data_lines, d[35:20]);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (line_results_q.size() != 0)
            begin
                $display("%0t: %0d line results never arrived, expected %0d first",
                         $time, line_results_q.size(), line_results_q[0].status);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    srec_line_scoreboard sb;
    logic [7:0] rec_chars[$];
    logic [7:0] rec_sum;
    bit         gaps_on;
    int         sent_items;
    int         quiet_cycles;

    srec_record_checker_core #(
        .MAX_RECORD_CHARS(MAX_CHARS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        return (n < 4'd10) ? CHAR_ZERO + 8'(n) : CHAR_A + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] flip_digit(logic [7:0] c);
        return (c == CHAR_ZERO) ? CHAR_A : CHAR_ZERO;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        rec_chars.push_back(hex_char(b[7:4]));
        rec_chars.push_back(hex_char(b[3:0]));
        rec_sum = rec_sum + b;
    endfunction

    // well-formed record of the given type with a correct count and checksum
    function automatic void build_record(logic [3:0] rtype, int n_data, logic [31:0] addr);
        int addr_bytes;
        addr_bytes = 2;
        if (rtype == REC_D24 || rtype == REC_END24)
            addr_bytes = 3;
        else if (rtype == REC_D32 || rtype == REC_END32)
            addr_bytes = 4;
        rec_chars = {};
        rec_sum = '0;
        rec_chars.push_back(CHAR_S);
        rec_chars.push_back(hex_char(rtype));
        push_byte(8'(addr_bytes + n_data + 1));
        for (int i = addr_bytes - 1; i >= 0; i--)
            push_byte(addr[8*i +: 8]);
        for (int i = 0; i < n_data; i++)
            push_byte(8'($urandom));
        push_byte(~rec_sum);
    endfunction

    function automatic void pad_to(int n);
        while (rec_chars.size() < n)
            rec_chars.push_back(hex_char(4'($urandom)));
    endfunction

    function automatic void corrupt_record(corrupt_t kind);
        int n;
        int i;
        n = rec_chars.size();
        i = (n > 0) ? $urandom_range(n - 1) : 0;
        case (kind)
            MUT_ANY_CHAR: if (n > 0) rec_chars[i] = 8'($urandom);
            MUT_HEX_CHAR: if (n > 0) rec_chars[i] = hex_char(4'($urandom));
            MUT_DROP:     if (n > 0) rec_chars.delete(i);
            MUT_INSERT:   rec_chars.insert(i, hex_char(4'($urandom)));
            MUT_CHECKSUM: if (n > 0) rec_chars[n-1] = flip_digit(rec_chars[n-1]);
            MUT_TYPE:     if (n > 1) rec_chars[1] = hex_char(4'($urandom));
            MUT_TRUNCATE: rec_chars = rec_chars[0:$urandom_range(n) - 1];
            MUT_PAD:      pad_to($urandom_range(79, 130));
            MUT_LOWER:    if (n > 0) rec_chars[i] = 8'($urandom_range(CHAR_LOWER_F, CHAR_LOWER_A));
            default:      ;
        endcase
    endfunction

    task automatic send(logic [7:0] c, logic eol);
        logic [7:0] d;
        while (gaps_on && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'($urandom);
            @(negedge clk);
        end
        d = eol ? 8'($urandom) : c;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tlast <= eol;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(d, eol);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_line();
        foreach (rec_chars[i])
            send(rec_chars[i], 1'b0);
        send(8'h0A, 1'b1);
    endtask

    // hold the input side until every line result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_directed();
        logic [3:0] bad_types[4];
        bad_types = '{REC_BAD4, REC_BAD6, REC_BADA, REC_BADF};
        rec_chars = {};
        send_line();
        rec_chars = {CHAR_S};
        send_line();
        build_record(REC_HDR, 3, 32'h0);
        send_line();
        build_record(REC_D16, 0, 32'hFFFF);
        send_line();
        build_record(REC_D16, 32, 32'h0000);
        send_line();
        build_record(REC_D24, 5, 32'h00ABCDEF);
        send_line();
        build_record(REC_D32, 32, 32'hFFFFFFFF);
        send_line();
        build_record(REC_CNT16, 0, {16'h0, sb.data_lines});
        send_line();
        build_record(REC_CNT16, 0, {16'h0, sb.data_lines + 16'd1});
        send_line();
        build_record(REC_END32, 0, 32'h12345678);
        send_line();
        build_record(REC_END24, 0, 32'h00123456);
        send_line();
        build_record(REC_END16, 0, 32'h1234);
        send_line();
        build_record(REC_HDR, 1, 32'h1200);
        send_line();
        foreach (bad_types[k])
        begin
            build_record(bad_types[k], 1, 32'h2000);
            send_line();
        end
        build_record(REC_D16, 1, 32'h1000);
        rec_chars[0] = CHAR_X;
        send_line();
        build_record(REC_D16, 1, 32'h1000);
        rec_chars[0] = 8'h00;
        send_line();
        build_record(REC_D16, 2, 32'h1000);
        rec_chars[5] = 8'hFF;
        send_line();
        build_record(REC_D16, 2, 32'h1000);
        rec_chars[6] = CHAR_LOWER_A;
        send_line();
        build_record(REC_D16, 2, 32'h1000);
        void'(rec_chars.pop_back());
        send_line();
        build_record(REC_D16, 2, 32'h1000);
        rec_chars[3] = flip_digit(rec_chars[3]);
        send_line();
        build_record(REC_D16, 2, 32'h1000);
        rec_chars[rec_chars.size()-1] = flip_digit(rec_chars[rec_chars.size()-1]);
        send_line();
        // data line past the length limit still counts as a data line
        build_record(REC_D16, 32, 32'h1000);
        pad_to(82);
        send_line();
        rec_chars = {CHAR_Q};
        for (int i = 0; i < 79; i++)
            rec_chars.push_back(8'($urandom));
        send_line();
    endtask

    task automatic run_random();
        logic [3:0] legal[8];
        logic [3:0] rtype;
        logic [31:0] addr;
        int n_data;
        int pick;
        int line_idx;
        int start_items;
        legal = '{REC_HDR, REC_D16, REC_D24, REC_D32, REC_CNT16, REC_END32, REC_END24,
                  REC_END16};
        line_idx = 0;
        start_items = sent_items;
        while (sent_items - start_items < RANDOM_ITEMS || line_idx < MIN_RANDOM_LINES)
        begin
            gaps_on = !(line_idx >= 1 && line_idx < 7);
            pick = $urandom_range(99);
            rtype = legal[$urandom_range(7)];
            if ($urandom_range(1) == 1)
                rtype = 4'($urandom_range(REC_D32, REC_D16));
            n_data = 0;
            if (rtype <= REC_D32)
                n_data = ($urandom_range(9) == 0) ? $urandom_range(32) : $urandom_range(6);
            addr = $urandom;
            if (rtype == REC_HDR && $urandom_range(9) != 0)
                addr = '0;
            if (rtype == REC_CNT16 && $urandom_range(3) != 0)
                addr = {16'h0, sb.data_lines};
            build_record(rtype, n_data, addr);
            if (pick >= 95)
            begin
                rec_chars = {};
                repeat ($urandom_range(20))
                    rec_chars.push_back(8'($urandom));
            end
            else if (pick >= 65)
                corrupt_record(corrupt_t'($urandom_range(MUT_LOWER)));
            send_line();
            if ($urandom_range(19) == 0)
                wait_drained();
            line_idx++;
        end
        gaps_on = 1;
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= gaps_on ? ($urandom_range(99) >= 16) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        gaps_on = 1;
        sent_items = 0;
        quiet_cycles = 0;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        wait_drained();
        run_random();
        wait_drained();
        repeat (8) @(posedge clk);
        sb.report_leftover();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
design/srec_pkg.sv
design/srec_char_tracker.sv
design/srec_line_judge.sv
design/srec_record_checker_core.sv
tb/tb_srec_record_checker_core.sv
